// File: rtl/core/hsv_range_pixel_count_detector_top_macros.svh
// Assertion macros used by the detector control FSM (hsvpc_ctrl).
`ifndef HSV_RANGE_PIXEL_COUNT_DETECTOR_TOP_MACROS_SVH
`define HSV_RANGE_PIXEL_COUNT_DETECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HSVPC_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hsvpc check failed");
`define HSVPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hsvpc check failed");
`else
`define HSVPC_ASSERT_SAME(label, clk, rst_n, pre, post)
`define HSVPC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/core/hsvpc_pkg.sv
`timescale 1ns / 1ps
package hsvpc_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int TALLY_W    = 23;
    localparam int SUM_W      = 31;
    localparam int DIV_W      = 32;
    localparam int DSR_W      = 9;

    localparam int unsigned MAX_FRAME_PIXELS = 4194304;
    localparam logic [TALLY_W-1:0] TALLY_CAP =
        (MAX_FRAME_PIXELS < 32'h7FFFFF) ? TALLY_W'(MAX_FRAME_PIXELS) : 23'h7FFFFF;

    // Q12 reciprocal numerators, doubled for round-to-nearest
    localparam logic [DIV_W-1:0] SAT_NUM = 32'd2088960;
    localparam logic [DIV_W-1:0] HUE_NUM = 32'd245760;
    localparam logic [29:0]      FIX_HALF = 30'd2048;
    localparam logic [30:0]      HUE_OFS  = 31'd739328;
    localparam logic [8:0]       HUE_SPAN = 9'd180;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_FR    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO      = 4'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SDIV_GO, ST_SDIV, ST_SMUL, ST_HDIV_GO, ST_HDIV, ST_HMUL,
        ST_MATCH, ST_FRAME, ST_MDIV_GO, ST_MDIV, ST_MEAN, ST_PMUL, ST_CMP
    } state_t;

    typedef enum logic [1:0] {
        DIV_SAT, DIV_HUE, DIV_MEAN
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     smul;
        logic     hmul;
        logic     match;
        logic     frame;
        logic     mean;
        logic     pmul;
        logic     cmp;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic need_mean;
    } status_t;

endpackage

// File: rtl/core/hsv_range_pixel_count_detector_top.sv
`timescale 1ns / 1ps
// HSV range pixel counter. Each RGB888 pixel is converted to 8-bit HSV (hue 0..179) and
// counted when hue, saturation and value all sit inside the inclusive bounds; the pixel
// with frame_end set closes the frame and yields one result beat with the frame count,
// calibration status and presence flag. Saturation and hue reciprocals each go through
// the shared 32-step radix-2 divider; a frame-end pixel adds frame, product and compare
// steps, plus a mean division (same divider) on the frame that completes calibration.
// The result beat is held in an output register, so the next pixel is accepted at once;
// a frame end stalls only while the previous result beat has still not been taken.
module hsv_range_pixel_count_detector_top
    import hsvpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TALLY_W-1:0]    in_range_count,
    output logic                  accessory_present,
    output logic                  is_calibrated,
    output logic                  was_baseline_frame
);

    cmd_t    cmd;
    status_t status;

    hsvpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    hsvpc_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .frame_end          (frame_end),
        .cmd                (cmd),
        .status             (status),
        .in_range_count     (in_range_count),
        .accessory_present  (accessory_present),
        .is_calibrated      (is_calibrated),
        .was_baseline_frame (was_baseline_frame)
    );

endmodule

// File: rtl/core/hsvpc_div.sv
`timescale 1ns / 1ps
module hsvpc_div
    import hsvpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [$clog2(DIV_W)-1:0] cnt_reg;
    logic [DIV_W-1:0]         quo_reg;
    logic [DSR_W-1:0]         rem_reg;
    logic [DSR_W-1:0]         dsr_reg;
    logic [DSR_W:0]           rem_shift;
    logic [DSR_W:0]           rem_sub;
    logic                     fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(DIV_W))'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DSR_W-1:0] : rem_shift[DSR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/hsvpc_ctrl.sv
`timescale 1ns / 1ps
`include "hsv_range_pixel_count_detector_top_macros.svh"
module hsvpc_ctrl
    import hsvpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.cmp)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_SDIV_GO;
            ST_SDIV_GO: state_next = ST_SDIV;
            ST_SDIV:    if (status.div_done) state_next = ST_SMUL;
            ST_SMUL:    state_next = ST_HDIV_GO;
            ST_HDIV_GO: state_next = ST_HDIV;
            ST_HDIV:    if (status.div_done) state_next = ST_HMUL;
            ST_HMUL:    state_next = ST_MATCH;
            ST_MATCH:   state_next = status.last ? ST_FRAME : ST_IDLE;
            ST_FRAME:   state_next = status.need_mean ? ST_MDIV_GO : ST_PMUL;
            ST_MDIV_GO: state_next = ST_MDIV;
            ST_MDIV:    if (status.div_done) state_next = ST_MEAN;
            ST_MEAN:    state_next = ST_PMUL;
            ST_PMUL:    state_next = ST_CMP;
            ST_CMP:     if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SAT;
            end
            ST_HDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_HUE;
            end
            ST_MDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
            end
            ST_SMUL:  cmd.smul  = 1'b1;
            ST_HMUL:  cmd.hmul  = 1'b1;
            ST_MATCH: cmd.match = 1'b1;
            ST_FRAME: cmd.frame = 1'b1;
            ST_MEAN:  cmd.mean  = 1'b1;
            ST_PMUL:  cmd.pmul  = 1'b1;
            ST_CMP:   cmd.cmp   = !out_valid_reg || out_ready;
            default:  cmd = '0;
        endcase
    end

    `HSVPC_ASSERT_NEXT(a_hold_beat, clk, rst_n, out_valid && !out_ready, out_valid)
    `HSVPC_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid && !out_ready, !cmd.cmp)
    `HSVPC_ASSERT_NEXT(a_wait_div, clk, rst_n,
        (state_reg == ST_SDIV) && !status.div_done, state_reg == ST_SDIV)
    `HSVPC_ASSERT_NEXT(a_publish, clk, rst_n, cmd.cmp, out_valid)

endmodule

// File: rtl/core/hsvpc_datapath.sv
`timescale 1ns / 1ps
module hsvpc_datapath
    import hsvpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic                  frame_end,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [TALLY_W-1:0]    in_range_count,
    output logic                  accessory_present,
    output logic                  is_calibrated,
    output logic                  was_baseline_frame
);

    logic [7:0]  hue_low_reg, hue_high_reg, sat_low_reg, sat_high_reg;
    logic [7:0]  value_low_reg, value_high_reg, base_fr_reg;
    logic [15:0] ratio_reg;

    logic [7:0]          v_reg, diff_reg;
    logic signed [11:0]  h_reg;
    logic                last_reg;
    logic [8:0]          s_reg, hq_reg;
    logic [TALLY_W-1:0]  tally_reg, count_reg, baseline_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [7:0]          taken_reg;
    logic                took_reg;
    logic [38:0]         rhs_reg;
    logic [38:0]         lhs_reg;

    logic [TALLY_W-1:0]  out_count_reg;
    logic                out_present_reg, out_calib_reg, out_took_reg;

    logic [7:0]          v_c, mn_c, diff_c;
    logic signed [11:0]  h_c;
    logic [DIV_W-1:0]    div_dvd;
    logic [DSR_W-1:0]    div_dsr;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    logic [20:0]         q_sat;
    logic [16:0]         q_hue;
    logic [29:0]         s_sum;
    logic signed [29:0]  h_prod;
    logic [30:0]         h_sum;
    logic [8:0]          hq_raw;
    logic                hit;
    logic [TALLY_W-1:0]  tally_inc;
    logic                took_c;
    logic [8:0]          taken_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg    <= 8'd0;
            hue_high_reg   <= 8'd179;
            sat_low_reg    <= 8'd0;
            sat_high_reg   <= 8'd255;
            value_low_reg  <= 8'd0;
            value_high_reg <= 8'd255;
            base_fr_reg    <= 8'd10;
            ratio_reg      <= 16'd384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HUE_LOW:    hue_low_reg    <= cfg_data[7:0];
                REG_HUE_HIGH:   hue_high_reg   <= cfg_data[7:0];
                REG_SAT_LOW:    sat_low_reg    <= cfg_data[7:0];
                REG_SAT_HIGH:   sat_high_reg   <= cfg_data[7:0];
                REG_VALUE_LOW:  value_low_reg  <= cfg_data[7:0];
                REG_VALUE_HIGH: value_high_reg <= cfg_data[7:0];
                REG_BASE_FR:    base_fr_reg    <= cfg_data[7:0];
                REG_RATIO:      ratio_reg      <= cfg_data;
                default:        ratio_reg      <= ratio_reg;
            endcase
        end
    end

    always_comb
    begin
        v_c  = red;
        mn_c = red;
        if (green > v_c) v_c = green;
        if (blue > v_c)  v_c = blue;
        if (green < mn_c) mn_c = green;
        if (blue < mn_c)  mn_c = blue;
        diff_c = v_c - mn_c;
        if (v_c == red)
            h_c = $signed({4'b0, green}) - $signed({4'b0, blue});
        else if (v_c == green)
            h_c = $signed({4'b0, blue}) - $signed({4'b0, red})
                + $signed({3'b0, diff_c, 1'b0});
        else
            h_c = $signed({4'b0, red}) - $signed({4'b0, green})
                + $signed({2'b0, diff_c, 2'b0});
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SAT:
            begin
                div_dvd = SAT_NUM + {24'b0, v_reg};
                div_dsr = {v_reg, 1'b0};
            end
            DIV_HUE:
            begin
                div_dvd = HUE_NUM + {24'b0, diff_reg};
                div_dsr = {diff_reg, 1'b0};
            end
            DIV_MEAN:
            begin
                div_dvd = {1'b0, sum_reg};
                div_dsr = {1'b0, taken_reg};
            end
            default:
            begin
                div_dvd = '0;
                div_dsr = '0;
            end
        endcase
    end

    hsvpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // gray and black take a zero reciprocal
    assign q_sat  = (v_reg == 8'd0) ? '0 : div_q[20:0];
    assign q_hue  = (diff_reg == 8'd0) ? '0 : div_q[16:0];
    assign s_sum  = ({1'b0, diff_reg * q_sat}) + FIX_HALF;
    assign h_prod = h_reg * $signed({1'b0, q_hue});
    assign h_sum  = 31'($signed({h_prod[29], h_prod})) + HUE_OFS;
    assign hq_raw = h_sum[20:12];

    assign hit = (hq_reg >= {1'b0, hue_low_reg}) && (hq_reg <= {1'b0, hue_high_reg})
              && (s_reg >= {1'b0, sat_low_reg}) && (s_reg <= {1'b0, sat_high_reg})
              && (v_reg >= value_low_reg) && (v_reg <= value_high_reg);
    assign tally_inc = (hit && (tally_reg < TALLY_CAP)) ? tally_reg + 1'b1 : tally_reg;

    assign took_c    = (taken_reg < base_fr_reg);
    assign taken_inc = {1'b0, taken_reg} + 9'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg    <= v_c;
            diff_reg <= diff_c;
            h_reg    <= h_c;
            last_reg <= frame_end;
        end
        if (cmd.smul)
            s_reg <= s_sum[20:12];
        if (cmd.hmul)
            hq_reg <= (hq_raw >= HUE_SPAN) ? hq_raw - HUE_SPAN : hq_raw;
        if (cmd.match)
            count_reg <= tally_inc;
        if (cmd.frame)
            took_reg <= took_c;
        if (cmd.pmul)
        begin
            rhs_reg <= baseline_reg * ratio_reg;
            lhs_reg <= {8'b0, count_reg, 8'b0};
        end
        if (cmd.cmp)
        begin
            out_count_reg   <= count_reg;
            out_present_reg <= !took_reg && (lhs_reg > rhs_reg);
            out_calib_reg   <= (taken_reg >= base_fr_reg);
            out_took_reg    <= took_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg    <= '0;
            sum_reg      <= '0;
            taken_reg    <= '0;
            baseline_reg <= '0;
        end
        else
        begin
            if (cmd.match)
                tally_reg <= last_reg ? '0 : tally_inc;
            if (cmd.frame && took_c)
            begin
                sum_reg   <= sum_reg + {8'b0, count_reg};
                taken_reg <= taken_inc[7:0];
            end
            if (cmd.mean)
                baseline_reg <= div_q[TALLY_W-1:0];
        end
    end

    assign status.last      = last_reg;
    assign status.div_done  = div_done;
    assign status.need_mean = took_c && (taken_inc >= {1'b0, base_fr_reg});

    assign in_range_count     = out_count_reg;
    assign accessory_present  = out_present_reg;
    assign is_calibrated      = out_calib_reg;
    assign was_baseline_frame = out_took_reg;

endmodule

// File: dv/hsvpc_checker.sv
`timescale 1ns / 1ps
module hsvpc_checker
    import hsvpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic                  frame_end,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [TALLY_W-1:0]    in_range_count,
    input  logic                  accessory_present,
    input  logic                  is_calibrated,
    input  logic                  was_baseline_frame,
    output int                    errors,
    output int                    pending
);

    typedef struct {
        logic [TALLY_W-1:0] count;
        logic               present;
        logic               calibrated;
        logic               took;
    } frame_report_t;

    frame_report_t report_q[$];

    logic [7:0]         hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi, calib_frames;
    logic [15:0]        ratio;
    logic [TALLY_W-1:0] tally;
    logic [SUM_W-1:0]   calib_sum;
    logic [7:0]         frames_seen;
    logic [TALLY_W-1:0] baseline;

    function automatic bit hsv_inside(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        int ri, gi, bi, vmax, vmin, diff, s, h, hq, ks, kh;
        ri = r;
        gi = g;
        bi = b;
        vmax = ri;
        vmin = ri;
        if (gi > vmax) vmax = gi;
        if (bi > vmax) vmax = bi;
        if (gi < vmin) vmin = gi;
        if (bi < vmin) vmin = bi;
        diff = vmax - vmin;
        ks = (vmax > 0) ? (2 * 255 * 4096 + vmax) / (2 * vmax) : 0;
        kh = (diff > 0) ? (2 * 30 * 4096 + diff) / (2 * diff) : 0;
        s = (diff * ks + 2048) >>> 12;
        if (vmax == ri) h = gi - bi;
        else if (vmax == gi) h = bi - ri + 2 * diff;
        else h = ri - gi + 4 * diff;
        hq = (h * kh + 2048 + (180 << 12)) >>> 12;
        if (hq >= 180) hq -= 180;
        return hq >= hue_lo && hq <= hue_hi && s >= sat_lo && s <= sat_hi &&
               vmax >= val_lo && vmax <= val_hi;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t exp_r, got;
        logic [TALLY_W-1:0] cnt;
        if (!rst_n)
        begin
            hue_lo = 0; hue_hi = 179; sat_lo = 0; sat_hi = 255;
            val_lo = 0; val_hi = 255; calib_frames = 10; ratio = 384;
            tally = 0; calib_sum = 0; frames_seen = 0; baseline = 0;
            report_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HUE_LOW:    hue_lo = cfg_data[7:0];
                    REG_HUE_HIGH:   hue_hi = cfg_data[7:0];
                    REG_SAT_LOW:    sat_lo = cfg_data[7:0];
                    REG_SAT_HIGH:   sat_hi = cfg_data[7:0];
                    REG_VALUE_LOW:  val_lo = cfg_data[7:0];
                    REG_VALUE_HIGH: val_hi = cfg_data[7:0];
                    REG_BASE_FR:    calib_frames = cfg_data[7:0];
                    REG_RATIO:      ratio = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = '{in_range_count, accessory_present, is_calibrated, was_baseline_frame};
                if (report_q.size() == 0)
                begin
                    $error("result beat with no frame pending");
                    errors++;
                end
                else
                begin
                    exp_r = report_q.pop_front();
                    if (got.count !== exp_r.count)
                    begin
                        $error("in_range_count exp %0d got %0d", exp_r.count, got.count);
                        errors++;
                    end
                    if (got.present !== exp_r.present)
                    begin
                        $error("accessory_present exp %0d got %0d", exp_r.present,
                               got.present);
                        errors++;
                    end
                    if (got.calibrated !== exp_r.calibrated)
                    begin
                        $error("is_calibrated exp %0d got %0d", exp_r.calibrated,
                               got.calibrated);
                        errors++;
                    end
                    if (got.took !== exp_r.took)
                    begin
                        $error("was_baseline_frame exp %0d got %0d", exp_r.took, got.took);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (hsv_inside(red, green, blue) && tally < TALLY_CAP)
                    tally = tally + 1'b1;
                if (frame_end)
                begin
                    cnt = tally;
                    tally = 0;
                    exp_r = '{cnt, 1'b0, 1'b0, 1'b0};
                    if (frames_seen < calib_frames)
                    begin
                        exp_r.took = 1'b1;
                        calib_sum = calib_sum + SUM_W'(cnt);
                        frames_seen = frames_seen + 8'd1;
                        if (frames_seen >= calib_frames)
                            baseline = TALLY_W'(calib_sum / SUM_W'(frames_seen));
                    end
                    else
                        exp_r.present = (longint'(cnt) * 256) > (longint'(baseline) * ratio);
                    exp_r.calibrated = frames_seen >= calib_frames;
                    report_q.push_back(exp_r);
                end
            end
            pending = report_q.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import hsvpc_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            red, green, blue;
    logic                  frame_end;
    logic                  out_valid;
    logic                  out_ready;
    logic [TALLY_W-1:0]    in_range_count;
    logic                  accessory_present, is_calibrated, was_baseline_frame;
    int                    errors, pending;
    int                    gap_pct, stall_pct, pixels_sent;
    int                    cycles = 0;

    hsv_range_pixel_count_detector_top dut (.*);

    hsvpc_checker chk (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_pressure();
        if (pixels_sent < ITEM_TARGET / 3)
        begin
            gap_pct = 8; stall_pct = 53;
        end
        else if (pixels_sent < 2 * ITEM_TARGET / 3)
        begin
            gap_pct = 53; stall_pct = 8;
        end
        else
        begin
            gap_pct = 0; stall_pct = 0;
        end
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic last);
        set_pressure();
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        frame_end <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
    endtask

    // drain every pending frame and let the pipeline empty out
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_all(input int hl, input int hh, input int sl, input int sh,
                               input int vl, input int vh, input int bf, input int ratio);
        drain();
        write_reg(REG_HUE_LOW, hl);
        write_reg(REG_HUE_HIGH, hh);
        write_reg(REG_SAT_LOW, sl);
        write_reg(REG_SAT_HIGH, sh);
        write_reg(REG_VALUE_LOW, vl);
        write_reg(REG_VALUE_HIGH, vh);
        write_reg(REG_BASE_FR, bf);
        write_reg(REG_RATIO, ratio);
    endtask

    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        int mode;
        mode = $urandom_range(9);
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        if (mode < 2)
        begin
            g = r;
            b = r;
        end
        else if (mode == 2)
        begin
            r = $urandom_range(1) ? 8'hFF : 8'h00;
            g = $urandom_range(1) ? 8'hFF : 8'h00;
            b = $urandom_range(1) ? r : g;
        end
        else if (mode == 3)
            b = 8'(r + $urandom_range(2) - 1);
    endtask

    task automatic random_frame();
        int n;
        logic [7:0] r, g, b;
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(10, 1);
        for (int i = 0; i < n; i++)
        begin
            random_pixel(r, g, b);
            send_pixel(r, g, b, i == n - 1);
        end
    endtask

    task automatic random_setting(input int phase);
        int a, c, d, e, f, h, bf, ratio;
        a = $urandom_range(179); c = $urandom_range(179);
        d = $urandom_range(255); e = $urandom_range(255);
        f = $urandom_range(255); h = $urandom_range(255);
        bf = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        ratio = $urandom_range(65535);
        case (phase % 6)
            0: program_all(0, 179, 0, 255, 0, 255, bf, 256);
            1: program_all(0, 179, 0, 255, 0, 255, 1, 0);
            2: program_all(a, c, d, e, f, h, bf, ratio);
            3: program_all(a < c ? a : c, a < c ? c : a, d < e ? d : e, d < e ? e : d,
                           0, 255, bf, 65535);
            4: program_all(a, 179, 0, e, f, 255, bf + 2, $urandom_range(512));
            default: program_all(0, c, d, 255, 0, h, bf, ratio);
        endcase
    endtask

    initial
    begin
        int phase, frames;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; red = '0; green = '0; blue = '0; frame_end = 1'b0;
        gap_pct = 0; stall_pct = 0; pixels_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two calibration frames over the color extremes, hue wrap included, then one scored frame
        write_reg(REG_BASE_FR, 2);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
        send_pixel(8'd1, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
        // narrow red window
        program_all(0, 10, 200, 255, 200, 255, 2, 128);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd250, 8'd10, 8'd5, 1'b0);
        send_pixel(8'd10, 8'd10, 8'd10, 1'b1);
        // inverted bounds match nothing
        program_all(100, 50, 255, 0, 255, 0, 2, 384);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
        // lower the calibration count below frames taken, then raise it
        program_all(0, 179, 0, 255, 0, 255, 0, 384);
        send_pixel(8'd7, 8'd200, 8'd90, 1'b1);
        program_all(0, 179, 0, 255, 0, 255, 4, 65535);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd12, 8'd34, 8'd56, 1'b0);
        send_pixel(8'd200, 8'd100, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b1);

        phase = 0;
        while (pixels_sent < ITEM_TARGET)
        begin
            random_setting(phase);
            frames = $urandom_range(12, 4);
            for (int i = 0; i < frames; i++)
                random_frame();
            phase++;
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hsvpc_pkg.sv
rtl/core/hsvpc_div.sv
rtl/core/hsvpc_ctrl.sv
rtl/core/hsvpc_datapath.sv
rtl/core/hsv_range_pixel_count_detector_top.sv
dv/hsvpc_checker.sv
dv/tb.sv
